/* rtl/ccpt_pkg.sv */
// Package for the call-context profiler table.
// Holds the shared constants, the request and status codes, the controller
// states and the key mixing function. No dependencies.
package ccpt_pkg;

  localparam int unsigned TABLE_SIZE_DEF = 2048;
  localparam logic [31:0] FNV_MULT       = 32'd16777619;
  localparam logic [31:0] ROOT_KEY       = 32'd16777619;
  localparam logic [7:0]  BYTE_MASK      = 8'hFF;

  typedef enum logic [1:0] {
    KIND_ENTER = 2'd0,
    KIND_LEAVE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FULL       = 2'd1,
    STATUS_LEAVE_ROOT = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_INSERT,
    ST_LMUL1,
    ST_LMUL2,
    ST_LWRITE,
    ST_REPORT
  } state_t;

  // One FNV-1 round: multiply by the FNV prime modulo 2^32, then XOR a byte.
  // The prime is 2^24 + 403, so the product is a shift plus a narrow multiply.
  function automatic logic [31:0] mix_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] prod;
    prod = (acc << 24) + acc * 32'd403;
    return prod ^ {24'd0, b & BYTE_MASK};
  endfunction

endpackage

/* rtl/call_context_profiler_table_top.sv */
// Top level of the call-context profiler table.
// Depends on ccpt_pkg; the slot record store is a memory inside this module.

// Requests are handled one at a time; the single-port-read record memory
// sets the pace. After reset the block clears all TABLE_SIZE records, one per
// cycle, before it accepts its first request. A read request, a leave at the
// root or a request of the unused kind goes straight to ST_REPORT. A leave
// passes through ST_LMUL1, ST_LMUL2 and ST_LWRITE; an enter mixes the key in
// ST_HASH, searches linearly in ST_PROBE and visits ST_INSERT when a new
// context is inserted (an enter that finds the table full probes every slot).
// A finished result waits in the output register while the next request is
// accepted; a result still waiting when the next one is ready holds the block.
module call_context_profiler_table_top #(
  parameter int unsigned TABLE_SIZE = ccpt_pkg::TABLE_SIZE_DEF,
  localparam int unsigned IDX_W  = $clog2(TABLE_SIZE),
  localparam int unsigned SLOT_W = IDX_W + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind,
  input  logic [31:0]       scope_hash,
  input  logic [63:0]       elapsed_time,
  input  logic [SLOT_W-1:0] slot_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SLOT_W-1:0] slot,
  output logic [SLOT_W-1:0] parent_slot,
  output logic              occupied,
  output logic [63:0]       max_time,
  output logic [63:0]       total_time,
  output logic [63:0]       square_total,
  output logic [31:0]       hit_count,
  output logic [1:0]        status
);
  import ccpt_pkg::*;

  localparam logic [SLOT_W-1:0] ROOT = SLOT_W'(TABLE_SIZE);
  localparam logic [IDX_W-1:0]  LAST = {IDX_W{1'b1}};

  typedef struct packed {
    logic              used;
    logic [31:0]       key;
    logic [SLOT_W-1:0] parent;
    logic [63:0]       mx;
    logic [63:0]       sm;
    logic [63:0]       sq;
    logic [31:0]       hits;
  } entry_t;

  entry_t mem [TABLE_SIZE];
  entry_t rdata;
  entry_t wdata;
  logic             we;
  logic             re;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;

  state_t state, state_next;
  logic [SLOT_W-1:0] cur;
  logic [SLOT_W-1:0] rs;
  status_t           rstat;
  logic [31:0]       acc;
  logic [31:0]       hash;
  logic [1:0]        cnt;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  probes;
  logic [63:0]       t;
  logic [63:0]       p0;
  logic [31:0]       p1;
  logic [SLOT_W-1:0] rd_slot;
  logic [31:0]       base;
  logic [31:0]       acc_in;
  logic [31:0]       key_next;
  logic [7:0]        hbyte;
  logic              hit;
  logic              out_free;
  logic              accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign rd_slot  = (slot_index > ROOT) ? ROOT : slot_index;
  assign base     = (cur < ROOT) ? rdata.key : ROOT_KEY;
  assign acc_in   = (cnt == 2'd0) ? base : acc;
  assign hbyte    = hash[8*(3-cnt) +: 8];
  assign key_next = mix_step(acc_in, hbyte);
  assign hit      = !rdata.used || (rdata.key == acc);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    we    = 1'b0;
    re    = 1'b0;
    waddr = idx;
    raddr = cur[IDX_W-1:0];
    wdata = '0;
    case (state)
      ST_CLEAR: begin
        we = 1'b1;
        if (idx == LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          re = 1'b1;
          case (kind)
            KIND_ENTER: state_next = ST_HASH;
            KIND_LEAVE: state_next = (cur < ROOT) ? ST_LMUL1 : ST_REPORT;
            KIND_READ: begin
              raddr = rd_slot[IDX_W-1:0];
              state_next = ST_REPORT;
            end
            default: state_next = ST_REPORT;
          endcase
        end
      end
      ST_HASH: begin
        if (cnt == 2'd3) begin
          re = 1'b1;
          raddr = key_next[IDX_W-1:0];
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (hit) begin
          if (!rdata.used) begin
            we = 1'b1;
            wdata.used   = 1'b1;
            wdata.key    = acc;
            wdata.parent = cur;
            state_next = ST_INSERT;
          end else begin
            state_next = ST_REPORT;
          end
        end else if (probes == LAST) begin
          re = 1'b1;
          state_next = ST_REPORT;
        end else begin
          re = 1'b1;
          raddr = idx + 1'b1;
        end
      end
      ST_INSERT: begin
        re = 1'b1;
        raddr = idx;
        state_next = ST_REPORT;
      end
      ST_LMUL1: state_next = ST_LMUL2;
      ST_LMUL2: state_next = ST_LWRITE;
      ST_LWRITE: begin
        we = 1'b1;
        waddr = cur[IDX_W-1:0];
        wdata = rdata;
        wdata.mx   = (t > rdata.mx) ? t : rdata.mx;
        wdata.sm   = rdata.sm + t;
        wdata.sq   = rdata.sq + p0 + {p1[30:0], 33'd0};
        wdata.hits = rdata.hits + 32'd1;
        re = 1'b1;
        raddr = rdata.parent[IDX_W-1:0];
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= ROOT;
      idx <= '0;
    end else begin
      case (state)
        ST_CLEAR: idx <= idx + 1'b1;
        ST_IDLE: begin
          if (accept) begin
            hash  <= scope_hash;
            t     <= elapsed_time;
            cnt   <= 2'd0;
            rstat <= (kind == KIND_LEAVE && cur >= ROOT) ? STATUS_LEAVE_ROOT : STATUS_OK;
            rs    <= (kind == KIND_READ) ? rd_slot : cur;
          end
        end
        ST_HASH: begin
          acc <= key_next;
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            idx    <= key_next[IDX_W-1:0];
            probes <= '0;
          end
        end
        ST_PROBE: begin
          if (hit) begin
            cur <= {1'b0, idx};
            rs  <= {1'b0, idx};
          end else if (probes == LAST) begin
            rstat <= STATUS_FULL;
          end else begin
            idx    <= idx + 1'b1;
            probes <= probes + 1'b1;
          end
        end
        ST_LMUL1: p0 <= t[31:0] * t[31:0];
        ST_LMUL2: p1 <= 32'(t[31:0] * t[63:32]);
        ST_LWRITE: begin
          cur <= rdata.parent;
          rs  <= rdata.parent;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_REPORT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_REPORT && out_free) begin
      slot   <= rs;
      status <= rstat;
      if (rs < ROOT && rdata.used) begin
        parent_slot  <= rdata.parent;
        occupied     <= 1'b1;
        max_time     <= rdata.mx;
        total_time   <= rdata.sm;
        square_total <= rdata.sq;
        hit_count    <= rdata.hits;
      end else begin
        parent_slot  <= ROOT;
        occupied     <= 1'b0;
        max_time     <= '0;
        total_time   <= '0;
        square_total <= '0;
        hit_count    <= '0;
      end
    end
  end

endmodule

/* rtl/ccpt_checker.sv */
// Port-level checks for the call-context profiler table.
// Depends on ccpt_pkg and is bound to call_context_profiler_table_top.
module ccpt_checker #(
  parameter int unsigned TABLE_SIZE = ccpt_pkg::TABLE_SIZE_DEF,
  localparam int unsigned SLOT_W = $clog2(TABLE_SIZE) + 1
) (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SLOT_W-1:0] slot,
  input logic [SLOT_W-1:0] parent_slot,
  input logic              occupied,
  input logic [63:0]       max_time,
  input logic [63:0]       total_time,
  input logic [63:0]       square_total,
  input logic [31:0]       hit_count,
  input logic [1:0]        status
);
  import ccpt_pkg::*;

  localparam logic [SLOT_W-1:0] ROOT = SLOT_W'(TABLE_SIZE);

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("Request accepted before the record store was cleared.");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(status))
    else $error("Waiting result changed.");

  a_empty_record: assert property (@(posedge clk) disable iff (rst)
    out_valid && !occupied |-> parent_slot == ROOT && max_time == 64'd0 &&
      total_time == 64'd0 && square_total == 64'd0 && hit_count == 32'd0)
    else $error("Unoccupied slot reported with statistics.");

  a_leave_root: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_LEAVE_ROOT |-> slot == ROOT && !occupied)
    else $error("Leave at root reported a slot other than the root.");

endmodule

bind call_context_profiler_table_top ccpt_checker #(.TABLE_SIZE(TABLE_SIZE)) u_ccpt_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
  .slot(slot), .parent_slot(parent_slot), .occupied(occupied), .max_time(max_time),
  .total_time(total_time), .square_total(square_total), .hit_count(hit_count),
  .status(status)
);
